[rtl/b64u_pkg.sv]
// Shared types, constants and the character table of the base64url stream encoder.
`timescale 1ns / 1ps
`default_nettype none

package b64u_pkg;

    // Beat widths on the byte side and the character side.
    localparam int DATA_W = 8;
    localparam int CHAR_W = 7;
    localparam int OUT_W  = 8;

    // Default depth of the group queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    // Number of bytes the front holds before the current one.
    localparam logic [1:0] POS_EMPTY = 2'd0;
    localparam logic [1:0] POS_ONE   = 2'd1;
    localparam logic [1:0] POS_TWO   = 2'd2;

    // Index of the last character a group gives.
    localparam logic [1:0] LAST_OF_TWO   = 2'd1;
    localparam logic [1:0] LAST_OF_THREE = 2'd2;
    localparam logic [1:0] LAST_OF_FOUR  = 2'd3;

    // One group of up to three bytes, ready to be turned into characters.
    typedef struct packed {
        logic [23:0] group;      // first byte in bits 23..16
        logic [1:0]  last_idx;   // index of the final character of this group
        logic        final_grp;  // group closes the message
    } t_job;

    // Map one sextet to its ASCII character in the base64url alphabet.
    function automatic logic [CHAR_W-1:0] sextet_to_char(input logic [5:0] idx);
        logic [CHAR_W-1:0] v;
        begin
            v = {1'b0, idx};
            if (idx < 6'd26) begin
                sextet_to_char = v + 7'd65;          // 'A'..'Z'
            end else if (idx < 6'd52) begin
                sextet_to_char = v + 7'd71;          // 'a'..'z'
            end else if (idx < 6'd62) begin
                sextet_to_char = v - 7'd4;           // '0'..'9'
            end else if (idx == 6'd62) begin
                sextet_to_char = 7'd45;              // '-'
            end else begin
                sextet_to_char = 7'd95;              // '_'
            end
        end
    endfunction

endpackage

`default_nettype wire

[rtl/base64url_stream_encoder_core.sv]
// Top level of the base64url stream encoder: front end, group queue and back end.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// The slave channel takes one message byte per beat in s_axis_tdata; s_axis_tlast
// marks the final byte of a message. The master channel gives one base64url
// character per beat in m_axis_tdata[6:0]; m_axis_tlast marks the message's final
// character. No '=' padding is produced.
// Every third byte, and every final byte, closes a group that goes into a short
// queue. The back end gives one character per cycle while the receiver is ready,
// and a full group of three bytes gives four characters; so the character output,
// not the byte input, sets the sustained rate. Bytes are taken every cycle while
// the queue has room. With an idle back end, a closing group is queued, then
// taken into the job register; its first character is then registered for m_axis.
// A synchronous active-low reset clears the held-byte count, the queue and
// the output register. When the receiver stalls, the output beat holds, the queue
// fills, and s_axis_tready then drops until a group slot frees up.

module base64url_stream_encoder_core #(
    parameter int QUEUE_DEPTH = b64u_pkg::QUEUE_DEPTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [b64u_pkg::DATA_W-1:0]   s_axis_tdata,   // [7:0] data_byte
    input  wire logic                          s_axis_tlast,   // end_of_message
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [b64u_pkg::OUT_W-1:0]         m_axis_tdata,   // [6:0] out_char, [7] zero
    output logic                               m_axis_tlast    // last_char
);

    logic                         push;
    logic                         pop;
    logic                         q_full;
    logic                         q_valid;
    b64u_pkg::t_job               push_job;
    b64u_pkg::t_job               head_job;
    logic [b64u_pkg::CHAR_W-1:0]  out_char;

    b64u_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_byte       (s_axis_tdata),
        .i_eom        (s_axis_tlast),
        .i_queue_full (q_full),
        .o_push       (push),
        .o_job        (push_job)
    );

    b64u_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    b64u_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_job   (head_job),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_char    (out_char),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_char};

endmodule

`default_nettype wire

[rtl/b64u_front.sv]
// Front end: accepts message bytes and packs them into groups for the queue.
`timescale 1ns / 1ps
`default_nettype none

module b64u_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [b64u_pkg::DATA_W-1:0]  i_byte,
    input  wire logic                         i_eom,
    input  wire logic                         i_queue_full,
    output logic                              o_push,
    output b64u_pkg::t_job                    o_job
);

    logic [15:0] r_held;
    logic [15:0] n_held;
    logic [1:0]  r_pos;
    logic [1:0]  n_pos;
    logic [1:0]  pos;
    logic        accept;
    logic        make_job;

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && make_job;

    // Classify the beat by how many bytes are already held.
    always_comb begin
        pos       = (r_pos == b64u_pkg::POS_TWO || r_pos == b64u_pkg::POS_ONE)
                    ? r_pos : b64u_pkg::POS_EMPTY;
        n_held    = r_held;
        n_pos     = r_pos;
        make_job  = 1'b0;
        o_job     = '0;
        unique case (pos)
            b64u_pkg::POS_ONE: begin
                if (i_eom) begin
                    make_job        = 1'b1;
                    o_job.group     = {r_held[15:8], i_byte, 8'h00};
                    o_job.last_idx  = b64u_pkg::LAST_OF_THREE;
                    o_job.final_grp = 1'b1;
                    n_pos           = b64u_pkg::POS_EMPTY;
                end else begin
                    n_held = {r_held[15:8], i_byte};
                    n_pos  = b64u_pkg::POS_TWO;
                end
            end
            b64u_pkg::POS_TWO: begin
                make_job        = 1'b1;
                o_job.group     = {r_held, i_byte};
                o_job.last_idx  = b64u_pkg::LAST_OF_FOUR;
                o_job.final_grp = i_eom;
                n_pos           = b64u_pkg::POS_EMPTY;
            end
            default: begin
                if (i_eom) begin
                    make_job        = 1'b1;
                    o_job.group     = {i_byte, 16'h0000};
                    o_job.last_idx  = b64u_pkg::LAST_OF_TWO;
                    o_job.final_grp = 1'b1;
                    n_pos           = b64u_pkg::POS_EMPTY;
                end else begin
                    n_held = {i_byte, 8'h00};
                    n_pos  = b64u_pkg::POS_ONE;
                end
            end
        endcase
    end

    // Position count and held bytes advance on every accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= b64u_pkg::POS_EMPTY;
        end else if (accept) begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held <= n_held;
        end
    end

`ifndef SYNTH
    // The position count never reaches three.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos != 2'd3)
        else $error("front position count out of range");

    // A third byte always completes a group.
    a_third_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_pos == b64u_pkg::POS_TWO) |-> o_push)
        else $error("third byte did not push a group");

    // After a final byte, the front holds nothing.
    a_eom_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_eom) |=> (r_pos == b64u_pkg::POS_EMPTY))
        else $error("position not cleared after final byte");
`endif

endmodule

`default_nettype wire

[rtl/b64u_queue.sv]
// Short queue of byte groups between the front end and the character back end.
`timescale 1ns / 1ps
`default_nettype none

module b64u_queue #(
    parameter int DEPTH = b64u_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire b64u_pkg::t_job i_job,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output b64u_pkg::t_job      o_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    b64u_pkg::t_job r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    // Pointers wrap at the queue depth.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage for queued groups.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

`ifndef SYNTH
    // The front never writes a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    // The back never takes from an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("pop from empty queue");

    // The entry count stays within the queue depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count past depth");
`endif

endmodule

`default_nettype wire

[rtl/b64u_back.sv]
// Back end: turns queued groups into base64url characters, one beat per cycle while the receiver is ready.
`timescale 1ns / 1ps
`default_nettype none

module b64u_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_q_valid,
    input  wire b64u_pkg::t_job                i_q_job,
    output logic                               o_pop,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [b64u_pkg::CHAR_W-1:0]        o_char,
    output logic                               o_last
);

    b64u_pkg::t_job r_job;
    logic [1:0]     r_idx;
    logic           r_busy;
    logic           r_out_valid;
    logic [b64u_pkg::CHAR_W-1:0] r_out_char;
    logic           r_out_last;

    logic           out_free;
    logic           advance;
    logic           done;
    logic [5:0]     sextet;

    assign out_free = !r_out_valid || i_ready;
    assign advance  = r_busy && out_free;
    assign done     = (r_idx == r_job.last_idx);
    assign o_pop    = i_q_valid && (!r_busy || (advance && done));

    assign o_valid  = r_out_valid;
    assign o_char   = r_out_char;
    assign o_last   = r_out_last;

    // Pick the sextet for the current character, most significant first.
    always_comb begin
        unique case (r_idx)
            2'd0:    sextet = r_job.group[23:18];
            2'd1:    sextet = r_job.group[17:12];
            2'd2:    sextet = r_job.group[11:6];
            default: sextet = r_job.group[5:0];
        endcase
    end

    // Job sequencing and output register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid <= r_busy;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (advance && done) begin
                r_busy <= 1'b0;
            end else if (advance) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_q_job;
        end
        if (advance) begin
            r_out_char <= b64u_pkg::sextet_to_char(sextet);
            r_out_last <= r_job.final_grp && done;
        end
    end

`ifndef SYNTH
    // The character index never runs past the group's last character.
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= r_job.last_idx))
        else $error("character index past end of group");

    // Every group gives at least two characters.
    a_min_chars: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_job.last_idx != 2'd0))
        else $error("group with fewer than two characters");

    // A busy back end fills a free output register on the next edge.
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("output register not loaded");
`endif

endmodule

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the base64url stream encoder core.
`timescale 1ns / 1ps

module testbench;

    // Watchdog limit in cycles without any accepted beat.
    localparam int IDLE_LIMIT  = 2000;
    // Character count at which the receiver starts its long hold-off, and its length.
    localparam int HOLD_AT     = 120;
    localparam int HOLD_CYCLES = 150;
    // Cycles allowed for the pipeline to settle after the last expected character.
    localparam int SETTLE      = 20;
    localparam int RANDOM_BYTES = 375;

    // One character beat as the encoder should deliver it.
    typedef struct packed {
        logic [b64u_pkg::CHAR_W-1:0] out_char;
        logic                        last_char;
    } t_char_beat;

    // Tracks the pending bytes of the encoder and the characters still owed by it.
    class b64u_scoreboard;
        logic [15:0]  held;
        logic [1:0]   pos;
        t_char_beat   owed[$];
        string        alphabet;
        int           errors;
        int           chars_seen;
        int           bytes_seen;
        int           messages;

        function new();
            held       = '0;
            pos        = b64u_pkg::POS_EMPTY;
            alphabet   = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";
            errors     = 0;
            chars_seen = 0;
            bytes_seen = 0;
            messages   = 0;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // Work out the characters one accepted byte releases.
        function void note_byte(logic [b64u_pkg::DATA_W-1:0] b, logic eom);
            logic [23:0] grp;
            int          count;
            logic        fin;
            t_char_beat  beat;
            byte         ch;
            count = 0;
            fin   = 1'b0;
            grp   = '0;
            bytes_seen++;
            if (eom) begin
                messages++;
            end
            case (pos)
                b64u_pkg::POS_ONE: begin
                    if (eom) begin
                        grp   = {held[15:8], b, 8'h00};
                        count = 3;
                        fin   = 1'b1;
                        held  = '0;
                        pos   = b64u_pkg::POS_EMPTY;
                    end else begin
                        held = {held[15:8], b};
                        pos  = b64u_pkg::POS_TWO;
                    end
                end
                b64u_pkg::POS_TWO: begin
                    grp   = {held, b};
                    count = 4;
                    fin   = eom;
                    held  = '0;
                    pos   = b64u_pkg::POS_EMPTY;
                end
                default: begin
                    // A position of three cannot occur; it counts as empty.
                    if (eom) begin
                        grp   = {b, 16'h0000};
                        count = 2;
                        fin   = 1'b1;
                        held  = '0;
                        pos   = b64u_pkg::POS_EMPTY;
                    end else begin
                        held = {b, 8'h00};
                        pos  = b64u_pkg::POS_ONE;
                    end
                end
            endcase
            for (int k = 0; k < count; k++) begin
                ch             = alphabet.getc(grp[23-6*k -: 6]);
                beat.out_char  = ch[b64u_pkg::CHAR_W-1:0];
                beat.last_char = fin && (k == count - 1);
                owed = {owed, beat};
            end
        endfunction

        // Compare one delivered character with the oldest one owed.
        function void check_char(logic [b64u_pkg::CHAR_W-1:0] c, logic l);
            t_char_beat want;
            chars_seen++;
            if (owed.size() == 0) begin
                $display("%0t: unexpected character: expected none, actual char %0d last %0b",
                         $time, c, l);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (c !== want.out_char) begin
                $display("%0t: out_char mismatch: expected %0d, actual %0d",
                         $time, want.out_char, c);
                errors++;
            end
            if (l !== want.last_char) begin
                $display("%0t: last_char mismatch: expected %0b, actual %0b",
                         $time, want.last_char, l);
                errors++;
            end
        endfunction
    endclass

    logic                        i_clk   = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        s_valid = 1'b0;
    logic [b64u_pkg::DATA_W-1:0] s_data  = '0;
    logic                        s_last  = 1'b0;
    logic                        m_ready = 1'b0;
    logic                        s_axis_tready;
    logic                        m_axis_tvalid;
    logic [b64u_pkg::OUT_W-1:0]  m_axis_tdata;
    logic                        m_axis_tlast;

    // Set during stretches in which neither side inserts random idle cycles.
    logic              steady = 1'b0;
    int                idle_cycles = 0;

    b64u_scoreboard    sb = new();

    base64url_stream_encoder_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),        // [7:0] data_byte
        .s_axis_tlast  (s_last),        // end_of_message
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),  // [6:0] out_char, [7] zero
        .m_axis_tlast  (m_axis_tlast)   // last_char
    );

    // Free-running clock, 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // End the run if no beat moves on either side for too long.
    always @(posedge i_clk) begin
        if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Watchdog expired at %0t with %0d characters owed", $time, sb.pending());
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 5);
    endfunction

    // Bytes lean toward the all-zero and all-one patterns now and then.
    function automatic logic [b64u_pkg::DATA_W-1:0] rand_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 8'h00;
        end else if (r == 1) begin
            return 8'hff;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Offer one byte after a random gap and hold it until the encoder takes it.
    task automatic send_byte(input logic [b64u_pkg::DATA_W-1:0] b, input logic eom);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        s_last  <= eom;
        do @(posedge i_clk); while (!(s_valid && s_axis_tready));
        sb.note_byte(b, eom);
    endtask

    task automatic send_message(input logic [b64u_pkg::DATA_W-1:0] msg[$]);
        for (int i = 0; i < msg.size(); i++) begin
            send_byte(msg[i], i == msg.size() - 1);
        end
    endtask

    // Stop offering bytes until every owed character has come out.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Receiver: random ready gaps, one long hold-off to back the encoder up.
    initial begin
        int gap;
        bit held_once;
        held_once = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = draw_gap();
            if (!held_once && sb.chars_seen >= HOLD_AT) begin
                gap       = HOLD_CYCLES;
                held_once = 1'b1;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_ready));
            sb.check_char(m_axis_tdata[b64u_pkg::CHAR_W-1:0], m_axis_tlast);
        end
    end

    // Stimulus: reset, directed messages, then random messages.
    initial begin
        logic [b64u_pkg::DATA_W-1:0] msg[$];
        int                len;
        int                sent;
        bit                drained_mid;
        drained_mid = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: one-byte, two-byte and whole-group endings, both alphabet ends.
        msg = '{8'h00};                                  send_message(msg);
        msg = '{8'hff};                                  send_message(msg);
        msg = '{8'hff, 8'h01};                           send_message(msg);
        msg = '{8'h00, 8'h00, 8'h00};                    send_message(msg);
        msg = '{8'hfb, 8'hff, 8'hbf};                    send_message(msg);
        msg = '{8'hff, 8'hff, 8'hff, 8'h00, 8'h10, 8'h83}; send_message(msg);
        msg = '{8'hf8, 8'h3e, 8'h0f, 8'hc1};             send_message(msg);
        msg = '{8'h12, 8'h34, 8'h56, 8'h78, 8'h9a};      send_message(msg);
        drain();

        // Random messages, mostly short, with some long ones.
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            steady = ($urandom_range(0, 7) == 0);
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 9);
            msg.delete();
            for (int i = 0; i < len; i++) begin
                msg = {msg, rand_byte()};
            end
            send_message(msg);
            sent += len;
            if (!drained_mid && sent >= RANDOM_BYTES / 2) begin
                drained_mid = 1'b1;
                drain();
            end
        end
        steady = 1'b0;
        drain();

        $display("Encoded %0d bytes in %0d messages; %0d characters checked, %0d errors.",
                 sb.bytes_seen, sb.messages, sb.chars_seen, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/b64u_pkg.sv
rtl/b64u_front.sv
rtl/b64u_queue.sv
rtl/b64u_back.sv
rtl/base64url_stream_encoder_core.sv
test/testbench.sv
